// File: hdl/stack_calculator_unit_assert.svh
// Assertion macros shared by the stack calculator unit RTL.
`ifndef STACK_CALCULATOR_UNIT_ASSERT_SVH
`define STACK_CALCULATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define SCU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies a consequence in the cycle after it.
`define SCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SCU_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/scu_pkg.sv
// Types and constants shared by the stack calculator unit files.
package scu_pkg;

  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_POP  = 3'd1,
    CMD_ADD  = 3'd2,
    CMD_SUB  = 3'd3,
    CMD_MUL  = 3'd4,
    CMD_DIV  = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_POP_EMPTY = 3'd1,
    STAT_FEW_OPS   = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_DIV_ZERO  = 3'd4
  } status_e;

  // Saturation limits of the signed fixed-point word
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  // Largest quotient magnitudes that still fit for each result sign
  localparam logic [DATA_W-1:0] MAG_MAX_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MAG_MAX_NEG = 32'h8000_0000;

endpackage

// File: hdl/scu_cmd_if.sv
// Command channel of the stack calculator unit.
interface scu_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [scu_pkg::CMD_W-1:0]           command;
  logic signed [scu_pkg::DATA_W-1:0]   push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

// File: hdl/scu_res_if.sv
// Result channel of the stack calculator unit.
interface scu_res_if;
  logic                                valid;
  logic                                ready;
  logic [scu_pkg::STATUS_W-1:0]        status;
  logic                                top_valid;
  logic signed [scu_pkg::DATA_W-1:0]   top_value;
  logic [scu_pkg::DEPTH_W-1:0]         stack_depth;

  modport source (output valid, output status, output top_valid, output top_value,
                  output stack_depth, input ready);
  modport sink   (input valid, input status, input top_valid, input top_value,
                  input stack_depth, output ready);
endinterface

// File: hdl/stack_calculator_unit.sv
// Top level of the stack calculator unit: sequencer, operand memory and shared datapath.
//
// A bounded operand stack of STACK_DEPTH signed fixed-point words (FRAC_BITS fraction
// bits) that takes one command per transfer on cmd_i and answers each with one
// transfer on res_o carrying the status, the new top entry and the new depth. The
// block takes one command at a time; cmd_i.ready is high while the sequencer is idle,
// also while an earlier result still sits in the output register. Push, no-op and
// every error case other than divide by zero go from idle straight to commit; pop,
// add, subtract and divide by zero pass through an execute state first, multiply
// then forms one registered 32x32 product and shifts and saturates it, and divide
// runs a restoring divider that retires one quotient bit per cycle. A result that
// is not yet taken holds the next command in its commit cycle until res_o.ready.
// Every read of the operand memory is registered and issued while idle. The memory
// needs no clearing after reset.
`include "stack_calculator_unit_assert.svh"

module stack_calculator_unit #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  scu_cmd_if.sink       cmd_i,
  scu_res_if.source     res_o
);

  localparam int DW      = scu_pkg::DATA_W;
  localparam int CntW    = $clog2(STACK_DEPTH + 1);
  localparam int AddrW   = $clog2(STACK_DEPTH);
  localparam int NumW    = DW + FRAC_BITS;
  localparam int DivCntW = $clog2(NumW);
  localparam int DepW    = scu_pkg::DEPTH_W;

  localparam logic signed [2*DW-1:0] MulMax = 64'sd2147483647;
  localparam logic signed [2*DW-1:0] MulMin = -64'sd2147483648;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DIVFIX,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_PUSH,
    UPD_POP,
    UPD_OP
  } upd_e;

  // Control
  state_e                 state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  scu_pkg::status_e       out_status_q, out_status_d;
  logic                   out_top_valid_q, out_top_valid_d;
  logic signed [DW-1:0]   out_top_q, out_top_d;
  logic [DepW-1:0]        out_depth_q, out_depth_d;

  // Datapath
  logic signed [DW-1:0]   top_q, top_d;
  logic [scu_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic signed [DW-1:0]   push_q, push_d;
  upd_e                   upd_q, upd_d;
  scu_pkg::status_e       status_q, status_d;
  logic signed [DW-1:0]   res_q, res_d;
  logic signed [2*DW-1:0] prod_q, prod_d;
  logic [DW-1:0]          rem_q, rem_d;
  logic [DW-1:0]          den_q, den_d;
  logic [NumW-1:0]        quo_q, quo_d;
  logic                   neg_q, neg_d;
  logic [DivCntW-1:0]     div_cnt_q, div_cnt_d;

  // Operand memory
  logic signed [DW-1:0]   mem_q [STACK_DEPTH];
  logic signed [DW-1:0]   rd_q;
  logic                   mem_we;
  logic [AddrW-1:0]       mem_wa;
  logic signed [DW-1:0]   mem_wd;

  logic [CntW-1:0]        cnt_m2;
  logic [AddrW-1:0]       below_addr;

  // Datapath intermediates
  logic signed [DW-1:0]   below, top;
  logic signed [DW:0]     sum_add, sum_sub;
  logic [DW-1:0]          abs_below, abs_top;
  logic signed [2*DW-1:0] mul_sh;
  logic [DW:0]            rem_sh, rem_diff;
  logic                   pos_ovf, neg_ovf;
  logic [CntW-1:0]        new_cnt;
  logic signed [DW-1:0]   new_top;
  logic [CntW+DepW-1:0]   depth_ext;

  assign cnt_m2     = cnt_q - CntW'(2);
  assign below_addr = cnt_m2[AddrW-1:0];

  assign below     = rd_q;
  assign top       = top_q;
  assign sum_add   = (DW+1)'(below) + (DW+1)'(top);
  assign sum_sub   = (DW+1)'(below) - (DW+1)'(top);
  assign abs_below = below[DW-1] ? (~below + DW'(1)) : below;
  assign abs_top   = top[DW-1] ? (~top + DW'(1)) : top;
  assign mul_sh    = prod_q >>> FRAC_BITS;
  assign rem_sh    = {rem_q, quo_q[NumW-1]};
  assign rem_diff  = rem_sh - {1'b0, den_q};
  assign pos_ovf   = !neg_q && (quo_q > NumW'(scu_pkg::MAG_MAX_POS));
  assign neg_ovf   = neg_q && (quo_q > NumW'(scu_pkg::MAG_MAX_NEG));

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    out_valid_d     = out_valid_q;
    out_status_d    = out_status_q;
    out_top_valid_d = out_top_valid_q;
    out_top_d       = out_top_q;
    out_depth_d     = out_depth_q;
    top_d           = top_q;
    cmd_d           = cmd_q;
    push_d          = push_q;
    upd_d           = upd_q;
    status_d        = status_q;
    res_d           = res_q;
    prod_d          = prod_q;
    rem_d           = rem_q;
    den_d           = den_q;
    quo_d           = quo_q;
    neg_d           = neg_q;
    div_cnt_d       = div_cnt_q;
    mem_we          = 1'b0;
    mem_wa          = below_addr;
    mem_wd          = res_q;
    new_cnt         = cnt_q;
    new_top         = top_q;
    depth_ext       = '0;

    // Drop the held result once it is taken
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d    = cmd_i.command;
          push_d   = cmd_i.push_value;
          status_d = scu_pkg::STAT_OK;
          upd_d    = UPD_NONE;
          state_d  = S_FINISH;
          case (cmd_i.command) inside
            scu_pkg::CMD_PUSH: begin
              if (cnt_q == CntW'(STACK_DEPTH)) begin
                status_d = scu_pkg::STAT_FULL;
              end else begin
                upd_d = UPD_PUSH;
              end
            end
            scu_pkg::CMD_POP: begin
              if (cnt_q == '0) begin
                status_d = scu_pkg::STAT_POP_EMPTY;
              end else begin
                upd_d   = UPD_POP;
                state_d = S_EXEC;
              end
            end
            scu_pkg::CMD_ADD, scu_pkg::CMD_SUB, scu_pkg::CMD_MUL, scu_pkg::CMD_DIV: begin
              if (cnt_q < CntW'(2)) begin
                status_d = scu_pkg::STAT_FEW_OPS;
              end else begin
                upd_d   = UPD_OP;
                state_d = S_EXEC;
              end
            end
            default: ;
          endcase
        end
      end

      S_EXEC: begin
        state_d = S_FINISH;
        case (cmd_q) inside
          scu_pkg::CMD_POP: begin
            res_d = below;
          end
          scu_pkg::CMD_ADD: begin
            if (sum_add[DW] != sum_add[DW-1]) begin
              res_d = sum_add[DW] ? scu_pkg::Q_MIN : scu_pkg::Q_MAX;
            end else begin
              res_d = sum_add[DW-1:0];
            end
          end
          scu_pkg::CMD_SUB: begin
            if (sum_sub[DW] != sum_sub[DW-1]) begin
              res_d = sum_sub[DW] ? scu_pkg::Q_MIN : scu_pkg::Q_MAX;
            end else begin
              res_d = sum_sub[DW-1:0];
            end
          end
          scu_pkg::CMD_MUL: begin
            prod_d  = (2*DW)'(below) * (2*DW)'(top);
            state_d = S_MUL;
          end
          scu_pkg::CMD_DIV: begin
            if (top == '0) begin
              status_d = scu_pkg::STAT_DIV_ZERO;
              if (below[DW-1]) begin
                res_d = scu_pkg::Q_MIN;
              end else if (below != '0) begin
                res_d = scu_pkg::Q_MAX;
              end else begin
                res_d = '0;
              end
            end else begin
              neg_d     = below[DW-1] ^ top[DW-1];
              den_d     = abs_top;
              quo_d     = NumW'(abs_below) << FRAC_BITS;
              rem_d     = '0;
              div_cnt_d = DivCntW'(NumW - 1);
              state_d   = S_DIV;
            end
          end
          default: ;
        endcase
      end

      S_MUL: begin
        // Arithmetic shift floors the product, then clamp
        if (mul_sh > MulMax) begin
          res_d = scu_pkg::Q_MAX;
        end else if (mul_sh < MulMin) begin
          res_d = scu_pkg::Q_MIN;
        end else begin
          res_d = mul_sh[DW-1:0];
        end
        state_d = S_FINISH;
      end

      S_DIV: begin
        // One restoring step per cycle on the magnitudes
        if (!rem_diff[DW]) begin
          rem_d = rem_diff[DW-1:0];
          quo_d = {quo_q[NumW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DW-1:0];
          quo_d = {quo_q[NumW-2:0], 1'b0};
        end
        if (div_cnt_q == '0) begin
          state_d = S_DIVFIX;
        end else begin
          div_cnt_d = div_cnt_q - DivCntW'(1);
        end
      end

      S_DIVFIX: begin
        if (pos_ovf) begin
          res_d = scu_pkg::Q_MAX;
        end else if (neg_ovf) begin
          res_d = scu_pkg::Q_MIN;
        end else if (neg_q) begin
          res_d = ~quo_q[DW-1:0] + DW'(1);
        end else begin
          res_d = quo_q[DW-1:0];
        end
        state_d = S_FINISH;
      end

      S_FINISH: begin
        // Commit the stack and load the result once the output register is free
        if (!out_valid_q || res_o.ready) begin
          unique case (upd_q)
            UPD_PUSH: begin
              mem_we  = 1'b1;
              mem_wa  = cnt_q[AddrW-1:0];
              mem_wd  = push_q;
              new_cnt = cnt_q + CntW'(1);
              new_top = push_q;
            end
            UPD_POP: begin
              new_cnt = cnt_q - CntW'(1);
              new_top = res_q;
            end
            UPD_OP: begin
              mem_we  = 1'b1;
              new_cnt = cnt_q - CntW'(1);
              new_top = res_q;
            end
            default: ;
          endcase
          depth_ext       = {{DepW{1'b0}}, new_cnt};
          cnt_d           = new_cnt;
          top_d           = new_top;
          out_valid_d     = 1'b1;
          out_status_d    = status_q;
          out_top_valid_d = (new_cnt != '0);
          out_top_d       = (new_cnt != '0) ? new_top : '0;
          out_depth_d     = depth_ext[DepW-1:0];
          state_d         = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      cnt_q           <= '0;
      out_valid_q     <= 1'b0;
      out_status_q    <= scu_pkg::STAT_OK;
      out_top_valid_q <= 1'b0;
      out_top_q       <= '0;
      out_depth_q     <= '0;
    end else begin
      state_q         <= state_d;
      cnt_q           <= cnt_d;
      out_valid_q     <= out_valid_d;
      out_status_q    <= out_status_d;
      out_top_valid_q <= out_top_valid_d;
      out_top_q       <= out_top_d;
      out_depth_q     <= out_depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    cmd_q     <= cmd_d;
    push_q    <= push_d;
    upd_q     <= upd_d;
    status_q  <= status_d;
    res_q     <= res_d;
    prod_q    <= prod_d;
    rem_q     <= rem_d;
    den_q     <= den_d;
    quo_q     <= quo_d;
    neg_q     <= neg_d;
    div_cnt_q <= div_cnt_d;
  end

  // Operand memory: one write port, one registered read of the entry below the top
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[below_addr];
  end

  assign cmd_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_status_q;
  assign res_o.top_valid   = out_top_valid_q;
  assign res_o.top_value   = out_top_q;
  assign res_o.stack_depth = out_depth_q;

  `SCU_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(STACK_DEPTH),
              "stack count beyond depth")
  `SCU_ASSERT(a_cnt_on_finish, clk_i, rst_ni,
              !$stable(cnt_q) |-> $past(state_q) == S_FINISH,
              "stack count moved outside commit")
  `SCU_ASSERT(a_div_rem, clk_i, rst_ni, (state_q == S_DIV) |-> (rem_q < den_q),
              "divider remainder not below divisor")
  `SCU_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, cmd_i.valid && cmd_i.ready,
                   state_q != S_IDLE, "sequencer idle after command transfer")
  `SCU_ASSERT_NEXT(a_finish_loads, clk_i, rst_ni,
                   (state_q == S_FINISH) && (!out_valid_q || res_o.ready),
                   out_valid_q && (state_q == S_IDLE), "commit did not load the result")

endmodule
